@@ src/mpp_pkg.sv @@
// Shared types, constants and helpers for the Markov page predictor.
`default_nettype none
package mpp_pkg;

  localparam int ADDR_W     = 11;
  localparam int PAGE_W     = 4;
  localparam int PID_W      = 4;
  localparam int PAGE_COUNT = 16;
  localparam int PAGE_BYTES = 128;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int TOP_ADDR   = PAGE_COUNT * PAGE_BYTES - 1;

  localparam logic [ADDR_W-1:0] LOOKAHEAD_RESET = ADDR_W'(100);

  typedef struct packed {
    logic [PID_W-1:0]  process_id;
    logic [ADDR_W-1:0] program_counter;
  } in_item_t;

  typedef struct packed {
    logic [PAGE_W-1:0] current_page;
    logic [PAGE_W-1:0] first_prediction;
    logic [PAGE_W-1:0] second_prediction;
    logic [PAGE_W-1:0] third_prediction;
    logic              release_previous;
    logic [PAGE_W-1:0] previous_page;
  } out_item_t;

  // Ranker control from the sequencer
  typedef struct packed {
    logic clear;
    logic en;
  } rank_ctl_t;

  typedef struct packed {
    logic [PAGE_W-1:0] p1;
    logic [PAGE_W-1:0] p2;
    logic [PAGE_W-1:0] p3;
  } picks_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_SCAN,
    ST_FIN
  } fsm_state_t;

  // Page of an address, saturating at the top of the space.
  function automatic logic [PAGE_W-1:0] page_of(input logic [ADDR_W:0] addr);
    logic [ADDR_W:0] a;
    a = addr;
    if (a > (ADDR_W+1)'(TOP_ADDR)) begin
      a = (ADDR_W+1)'(TOP_ADDR);
    end
    return PAGE_W'(a >> PAGE_SHIFT);
  endfunction

endpackage
`default_nettype wire

@@ src/mpp_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mpp_ram #(
  parameter int WIDTH  = 16,
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output      logic [WIDTH-1:0]  rdata
);

  localparam int DEPTH = 2 ** ADDR_W;

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ src/mpp_ranker.sv @@
// Streaming ranker: keeps the top three counts and the best count below the maximum.
`default_nettype none
module mpp_ranker #(
  parameter int COUNT_BITS = 16
) (
  input  wire logic                          clk,
  input  wire mpp_pkg::rank_ctl_t            ctl,
  input  wire logic [mpp_pkg::PAGE_W-1:0]    idx,
  input  wire logic [COUNT_BITS-1:0]         count,
  input  wire logic [mpp_pkg::PAGE_W-1:0]    ahead,
  output      mpp_pkg::picks_t               picks
);

  logic [COUNT_BITS-1:0]      t0v_r, t1v_r, t2v_r, b2v_r;
  logic [mpp_pkg::PAGE_W-1:0] t0i_r, t1i_r, t2i_r, b2i_r;

  // Entries arrive in increasing index order, so a later entry only
  // outranks an earlier one on a strictly larger count.
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      t0v_r <= '0;
      t1v_r <= '0;
      t2v_r <= '0;
      b2v_r <= '0;
    end else if (ctl.en) begin
      if (count > t0v_r) begin
        t0v_r <= count;  t0i_r <= idx;
        t1v_r <= t0v_r;  t1i_r <= t0i_r;
        t2v_r <= t1v_r;  t2i_r <= t1i_r;
        b2v_r <= t0v_r;  b2i_r <= t0i_r;
      end else begin
        if (count > t1v_r) begin
          t1v_r <= count;  t1i_r <= idx;
          t2v_r <= t1v_r;  t2i_r <= t1i_r;
        end else if (count > t2v_r) begin
          t2v_r <= count;  t2i_r <= idx;
        end
        if (count < t0v_r && count > b2v_r) begin
          b2v_r <= count;  b2i_r <= idx;
        end
      end
    end
  end

  logic [mpp_pkg::PAGE_W-1:0] p1, p2, p3;

  always_comb begin
    p1 = (t0v_r != '0) ? t0i_r : ahead;
    p2 = (b2v_r != '0) ? b2i_r : ahead;
    // third pick is the best ranked entry that is neither of the first two
    if (t0v_r != '0 && t0i_r != p1 && t0i_r != p2) begin
      p3 = t0i_r;
    end else if (t1v_r != '0 && t1i_r != p1 && t1i_r != p2) begin
      p3 = t1i_r;
    end else if (t2v_r != '0 && t2i_r != p1 && t2i_r != p2) begin
      p3 = t2i_r;
    end else begin
      p3 = ahead;
    end
  end

  assign picks.p1 = p1;
  assign picks.p2 = p2;
  assign picks.p3 = p3;

endmodule
`default_nettype wire

@@ src/markov_page_predictor_core.sv @@
// Markov page predictor: per-process transition counts in RAM, row scan for predictions.
//
//  channel   ports                        direction  protocol
//  input     in_valid/in_ready/in_data    in         valid-ready, one access per transfer
//  result    out_valid/out_ready/out_data out        valid-ready, one result per in-range access
//  config    cfg_we/cfg_wdata             in         write strobe, lookahead register
//
// An access runs the count read-modify-write (skipped when there is no transition), then
// one RAM read per counter of the lookahead row, one read per cycle.
// After reset a clearing pass zeroes the count RAM, with in_ready low.
// Accesses with an out-of-range process id are dropped. A pending result waits in the
// output register; the next access is taken meanwhile and stalls only at its own end.
`default_nettype none
module markov_page_predictor_core #(
  parameter int PROCESS_COUNT = 16,
  parameter int COUNT_BITS    = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output      logic                               in_ready,
  input  wire mpp_pkg::in_item_t                  in_data,
  output      logic                               out_valid,
  input  wire logic                               out_ready,
  output      mpp_pkg::out_item_t                 out_data,
  input  wire logic                               cfg_we,
  input  wire logic [mpp_pkg::ADDR_W-1:0]         cfg_wdata
);

  localparam int PW    = (PROCESS_COUNT > 1) ? $clog2(PROCESS_COUNT) : 1;
  localparam int PGW   = mpp_pkg::PAGE_W;
  localparam int MEM_W = PW + 2 * PGW;

  mpp_pkg::fsm_state_t state_r, state_nxt;

  logic [mpp_pkg::ADDR_W-1:0] lookahead_r;
  logic [MEM_W-1:0]           clr_r;
  logic [PGW:0]               col_r;
  logic                       dv_r;
  logic [PGW-1:0]             didx_r;
  logic [PW-1:0]              proc_r;
  logic [PGW-1:0]             cur_r, ahead_r, prev_r;
  logic                       have_prev_r;
  logic                       lp_valid_r [PROCESS_COUNT];
  logic [PGW-1:0]             lp_page_r  [PROCESS_COUNT];
  logic                       out_valid_r;
  mpp_pkg::out_item_t         out_data_r;

  logic                  in_fire, in_ok, out_free, load_out;
  logic [PW-1:0]         in_proc;
  logic [PGW-1:0]        in_cur, in_ahead;
  logic                  ram_we;
  logic [MEM_W-1:0]      ram_waddr, ram_raddr, upd_addr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;
  mpp_pkg::rank_ctl_t    rctl;
  mpp_pkg::picks_t       picks;

  assign in_fire  = in_valid && in_ready;
  assign in_ok    = 32'(in_data.process_id) < PROCESS_COUNT;
  assign in_proc  = PW'(in_data.process_id);
  assign in_cur   = mpp_pkg::page_of({1'b0, in_data.program_counter});
  assign in_ahead = mpp_pkg::page_of({1'b0, in_data.program_counter} + {1'b0, lookahead_r});
  assign out_free = !out_valid_r || out_ready;
  assign upd_addr = {proc_r, prev_r, cur_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mpp_pkg::ST_CLEAR: begin
        if (&clr_r) state_nxt = mpp_pkg::ST_IDLE;
      end
      mpp_pkg::ST_IDLE: begin
        if (in_valid && in_ok) begin
          if (lp_valid_r[in_proc] && lp_page_r[in_proc] != in_cur) begin
            state_nxt = mpp_pkg::ST_UPD_RD;
          end else begin
            state_nxt = mpp_pkg::ST_SCAN;
          end
        end
      end
      mpp_pkg::ST_UPD_RD: state_nxt = mpp_pkg::ST_UPD_WR;
      mpp_pkg::ST_UPD_WR: state_nxt = mpp_pkg::ST_SCAN;
      mpp_pkg::ST_SCAN: begin
        if (col_r[PGW]) state_nxt = mpp_pkg::ST_FIN;
      end
      mpp_pkg::ST_FIN: begin
        if (out_free) state_nxt = mpp_pkg::ST_IDLE;
      end
      default: state_nxt = mpp_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready   = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = upd_addr;
    ram_wdata  = (ram_rdata == '1) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
    ram_raddr  = {proc_r, ahead_r, col_r[PGW-1:0]};
    rctl.clear = 1'b0;
    rctl.en    = dv_r;
    load_out   = 1'b0;
    case (state_r)
      mpp_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      mpp_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        rctl.clear = 1'b1;
      end
      mpp_pkg::ST_UPD_RD: ram_raddr = upd_addr;
      mpp_pkg::ST_UPD_WR: ram_we = 1'b1;
      mpp_pkg::ST_SCAN:   ;
      mpp_pkg::ST_FIN:    load_out = out_free;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mpp_pkg::ST_CLEAR;
      lookahead_r <= mpp_pkg::LOOKAHEAD_RESET;
      clr_r       <= '0;
      col_r       <= '0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int p = 0; p < PROCESS_COUNT; p++) begin
        lp_valid_r[p] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) lookahead_r <= cfg_wdata;
      if (state_r == mpp_pkg::ST_CLEAR) clr_r <= clr_r + MEM_W'(1);

      dv_r   <= (state_r == mpp_pkg::ST_SCAN) && !col_r[PGW];
      didx_r <= col_r[PGW-1:0];
      if (in_fire) begin
        col_r <= '0;
      end else if (state_r == mpp_pkg::ST_SCAN && !col_r[PGW]) begin
        col_r <= col_r + (PGW+1)'(1);
      end

      if (in_fire && in_ok) begin
        proc_r              <= in_proc;
        cur_r               <= in_cur;
        ahead_r             <= in_ahead;
        prev_r              <= lp_page_r[in_proc];
        have_prev_r         <= lp_valid_r[in_proc];
        lp_valid_r[in_proc] <= 1'b1;
        lp_page_r[in_proc]  <= in_cur;
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r.current_page      <= cur_r;
      out_data_r.first_prediction  <= picks.p1;
      out_data_r.second_prediction <= picks.p2;
      out_data_r.third_prediction  <= picks.p3;
      out_data_r.release_previous  <= have_prev_r && prev_r != cur_r && picks.p1 != prev_r
                                      && picks.p2 != prev_r && picks.p3 != prev_r;
      out_data_r.previous_page     <= have_prev_r ? prev_r : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mpp_ram #(
    .WIDTH  (COUNT_BITS),
    .ADDR_W (MEM_W)
  ) u_counts (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpp_ranker #(
    .COUNT_BITS (COUNT_BITS)
  ) u_ranker (
    .clk   (clk),
    .ctl   (rctl),
    .idx   (didx_r),
    .count (ram_rdata),
    .ahead (ahead_r),
    .picks (picks)
  );

endmodule
`default_nettype wire

@@ sim/markov_page_predictor_core_tb.sv @@
// Testbench for markov_page_predictor_core: directed and random accesses with scoreboard checking.
`timescale 1ns / 1ps
module markov_page_predictor_core_tb;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;
  localparam logic [15:0] COUNT_TOP = 16'hFFFF;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_HALF,
    RX_SPARSE,
    RX_PERIODIC
  } rx_mode_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mpp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mpp_pkg::out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [mpp_pkg::ADDR_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [15:0] trans_count [16][16][16];
  logic last_ok [16];
  logic [mpp_pkg::PAGE_W-1:0] last_pg [16];
  logic [mpp_pkg::ADDR_W-1:0] lookahead_q;
  mpp_pkg::out_item_t predicted_pages_q [$];

  int cycle_count = 0;
  int burst_left = 0;
  int accesses_sent = 0;
  int results_checked = 0;
  int mismatches = 0;
  int hold_seq = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  rx_mode_t rx_mode = RX_OPEN;

  always #2 clk = ~clk;

  markov_page_predictor_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic logic [mpp_pkg::PAGE_W-1:0] page_index(
    input logic [mpp_pkg::ADDR_W:0] addr);
    if (addr > (mpp_pkg::ADDR_W+1)'(mpp_pkg::TOP_ADDR)) begin
      addr = (mpp_pkg::ADDR_W+1)'(mpp_pkg::TOP_ADDR);
    end
    return mpp_pkg::PAGE_W'(addr >> mpp_pkg::PAGE_SHIFT);
  endfunction

  // Highest nonzero count in row src, lowest index on ties; src when nothing qualifies.
  function automatic logic [mpp_pkg::PAGE_W-1:0] best_successor(
    input logic [3:0] pid, input logic [3:0] src,
    input logic use_cap, input logic [15:0] cap,
    input logic use_skip, input logic [3:0] skip_a, input logic [3:0] skip_b);
    logic [mpp_pkg::PAGE_W-1:0] best;
    logic [15:0] top_val;
    logic [15:0] c;
    int i;
    best = src;
    top_val = '0;
    for (i = 0; i < mpp_pkg::PAGE_COUNT; i++) begin
      c = trans_count[pid][src][i];
      if (c > top_val && !(use_cap && c >= cap) &&
          !(use_skip && (4'(i) == skip_a || 4'(i) == skip_b))) begin
        best = 4'(i);
        top_val = c;
      end
    end
    return best;
  endfunction

  function automatic void predict_pages(input mpp_pkg::in_item_t item);
    mpp_pkg::out_item_t res;
    logic [3:0] pid;
    logic [3:0] cur;
    logic [3:0] ahead;
    logic [3:0] prev;
    logic have_prev;
    pid = item.process_id;
    cur = page_index({1'b0, item.program_counter});
    have_prev = last_ok[pid];
    prev = last_pg[pid];
    if (have_prev && prev != cur && trans_count[pid][prev][cur] != COUNT_TOP) begin
      trans_count[pid][prev][cur] = trans_count[pid][prev][cur] + 16'd1;
    end
    ahead = page_index({1'b0, item.program_counter} + {1'b0, lookahead_q});
    res.current_page = cur;
    res.first_prediction = best_successor(pid, ahead, 1'b0, '0, 1'b0, '0, '0);
    res.second_prediction = best_successor(pid, ahead, 1'b1,
                                           trans_count[pid][ahead][res.first_prediction],
                                           1'b0, '0, '0);
    res.third_prediction = best_successor(pid, ahead, 1'b0, '0, 1'b1,
                                          res.first_prediction, res.second_prediction);
    res.release_previous = have_prev && prev != cur && res.first_prediction != prev &&
                           res.second_prediction != prev && res.third_prediction != prev;
    res.previous_page = have_prev ? prev : '0;
    last_ok[pid] = 1'b1;
    last_pg[pid] = cur;
    predicted_pages_q.push_back(res);
  endfunction

  // Caller must be at a rising edge; returns at the edge of the transfer.
  task automatic send_access(input logic [3:0] pid, input logic [mpp_pkg::ADDR_W-1:0] pc);
    mpp_pkg::in_item_t item;
    item.process_id = pid;
    item.program_counter = pc;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_pages(item);
    accesses_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (predicted_pages_q.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Only called with the block idle.
  task automatic set_lookahead(input logic [mpp_pkg::ADDR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    lookahead_q = value;
  endtask

  task automatic test_first_access();
    // no previous page, empty row: all picks fall back to the lookahead page
    send_access(4'd0, 11'd0);
    wait_drained();
  endtask

  task automatic test_address_extremes();
    send_access(4'd15, 11'd2047);
    send_access(4'd15, 11'd0);
    send_access(4'd15, 11'd2047);
    send_access(4'd15, 11'd1920);   // same page, no transition
    send_access(4'd8, 11'd1023);
    wait_drained();
  endtask

  task automatic test_lookahead_extremes();
    set_lookahead(11'd2047);        // pc + lookahead clamps to the top page
    send_access(4'd3, 11'd5);
    send_access(4'd3, 11'd2040);
    wait_drained();
    set_lookahead(11'd0);
    send_access(4'd3, 11'd5);
    wait_drained();
  endtask

  task automatic test_successor_ranking();
    logic [3:0] walk [9];
    int k;
    // row of page 2 ends as 5:2, 3:1, 7:1 -> tie on the second pick
    walk = '{4'd2, 4'd5, 4'd2, 4'd7, 4'd2, 4'd5, 4'd2, 4'd3, 4'd2};
    for (k = 0; k < 9; k++) begin
      send_access(4'd1, {walk[k], 7'($urandom_range(0, 127))});
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    logic [3:0] pg;
    int k;
    hold_seq++;
    burst_left = 1000;              // keep offering through the hold-off
    for (k = 0; k < 24; k++) begin
      pg = 4'((k % 3) * 4 + 1);
      send_access(4'd9, {pg, 7'($urandom_range(0, 127))});
    end
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n, input logic [mpp_pkg::ADDR_W-1:0] la);
    logic [3:0] loop_pg [16][4];
    int step [16];
    logic [3:0] pid;
    logic [3:0] pg;
    logic [3:0] pid_base;
    int k;
    int j;
    set_lookahead(la);
    pid_base = 4'($urandom_range(0, 15));
    for (k = 0; k < 16; k++) begin
      step[k] = 0;
      for (j = 0; j < 4; j++) begin
        loop_pg[k][j] = 4'($urandom_range(0, 15));
      end
    end
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        // a few processes cycling through their page loops
        pid = pid_base + 4'($urandom_range(0, 3));
        if ($urandom_range(0, 99) < 80) begin
          pg = loop_pg[pid][step[pid] % 4];
          step[pid]++;
        end else begin
          pg = 4'($urandom_range(0, 15));
        end
        send_access(pid, {pg, 7'($urandom_range(0, 127))});
      end else begin
        send_access(4'($urandom_range(0, 15)), 11'($urandom_range(0, 2047)));
      end
    end
    wait_drained();
  endtask

  // receiver: stall pattern plus an on-demand long hold-off
  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        mode_left <= $urandom_range(32, 200);
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      end else begin
        mode_left <= mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= (cycle_count % 4 == 0);
      endcase
    end
  end

  always @(posedge clk) begin : check_result
    mpp_pkg::out_item_t exp_item;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_pages_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: cur=%0d p=%0d/%0d/%0d rel=%0d prev=%0d",
                   out_data.current_page, out_data.first_prediction,
                   out_data.second_prediction, out_data.third_prediction,
                   out_data.release_previous, out_data.previous_page);
        end
      end else begin
        exp_item = predicted_pages_q.pop_front();
        results_checked++;
        if (out_data.current_page !== exp_item.current_page ||
            out_data.first_prediction !== exp_item.first_prediction ||
            out_data.second_prediction !== exp_item.second_prediction ||
            out_data.third_prediction !== exp_item.third_prediction ||
            out_data.release_previous !== exp_item.release_previous ||
            out_data.previous_page !== exp_item.previous_page) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: exp cur=%0d p=%0d/%0d/%0d rel=%0d prev=%0d",
                     results_checked, exp_item.current_page, exp_item.first_prediction,
                     exp_item.second_prediction, exp_item.third_prediction,
                     exp_item.release_previous, exp_item.previous_page);
            $display("           act cur=%0d p=%0d/%0d/%0d rel=%0d prev=%0d",
                     out_data.current_page, out_data.first_prediction,
                     out_data.second_prediction, out_data.third_prediction,
                     out_data.release_previous, out_data.previous_page);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count,
               predicted_pages_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int p = 0; p < 16; p++) begin
      last_ok[p] = 1'b0;
      last_pg[p] = '0;
      for (int a = 0; a < 16; a++) begin
        for (int b = 0; b < 16; b++) begin
          trans_count[p][a][b] = '0;
        end
      end
    end
    lookahead_q = mpp_pkg::LOOKAHEAD_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_first_access();
    test_address_extremes();
    test_lookahead_extremes();
    test_successor_ranking();
    test_random_traffic(100, 11'($urandom_range(1, 2046)));
    test_random_traffic(100, 11'd0);
    test_random_traffic(100, 11'd2047);
    set_lookahead(11'd100);
    test_backpressure();
    test_random_traffic(100, 11'd100);

    repeat (40) @(posedge clk);
    $display("%0d accesses sent, %0d results checked, %0d mismatches",
             accesses_sent, results_checked, mismatches);
    $display("lookahead 0, 2047, 100 and random; long output hold-off with input stall");
    if (mismatches == 0 && predicted_pages_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ markov_page_predictor_core.f @@
src/mpp_pkg.sv
src/mpp_ram.sv
src/mpp_ranker.sv
src/markov_page_predictor_core.sv
sim/markov_page_predictor_core_tb.sv
